// File: hdl/iclp_pkg.sv
// ----------------------------------------------------------------------------
// iclp_pkg
// shared types and constants of the install command tlv parser
// ----------------------------------------------------------------------------
package iclp_pkg;

    localparam int HEADER_BYTES  = 5;
    localparam int MIN_ID_LENGTH = 5;
    localparam int MAX_ID_LENGTH = 16;

    localparam logic [8:0] POS_MAX = 9'd511;

    // command fields
    localparam logic [8:0] POS_P1 = 9'd2;
    localparam logic [8:0] POS_P2 = 9'd3;
    localparam logic [8:0] POS_LC = 9'd4;

    localparam logic [7:0] MODE_SELECTABLE = 8'h00;
    localparam logic [7:0] MODE_INSTALL    = 8'h02;

    localparam logic [7:0] TAG_APP_ID    = 8'h4F;
    localparam logic [7:0] TAG_MODULE_ID = 8'hCB;
    localparam logic [7:0] TAG_PARAMS    = 8'hC4;

    // byte roles
    localparam logic [2:0] ROLE_HEADER = 3'd0;
    localparam logic [2:0] ROLE_TAG    = 3'd1;
    localparam logic [2:0] ROLE_LENGTH = 3'd2;
    localparam logic [2:0] ROLE_APP    = 3'd3;
    localparam logic [2:0] ROLE_MODULE = 3'd4;
    localparam logic [2:0] ROLE_PARAM  = 3'd5;
    localparam logic [2:0] ROLE_SKIP   = 3'd6;
    localparam logic [2:0] ROLE_IGNORE = 3'd7;

    // error causes
    localparam logic [3:0] ERR_NONE      = 4'd0;
    localparam logic [3:0] ERR_MODE      = 4'd1;
    localparam logic [3:0] ERR_NO_DATA   = 4'd2;
    localparam logic [3:0] ERR_TRUNC     = 4'd3;
    localparam logic [3:0] ERR_OVERRUN   = 4'd4;
    localparam logic [3:0] ERR_ID_LENGTH = 4'd5;
    localparam logic [3:0] ERR_NO_APP    = 4'd6;
    localparam logic [3:0] ERR_NO_MODULE = 4'd7;
    localparam logic [3:0] ERR_SHORT     = 4'd8;

    // status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_P1P2   = 2'd1;
    localparam logic [1:0] ST_WRONG_DATA = 2'd2;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        PH_TAG    = 3'b001,
        PH_LENGTH = 3'b010,
        PH_VALUE  = 3'b100
    } t_phase;

    // one classified byte, as handed from front to back
    typedef struct packed {
        logic [2:0] role;
        logic [7:0] value;
        logic [7:0] vidx;
        logic       done;
        logic [3:0] cause;
        logic       install;
        logic [4:0] app_len;
        logic [4:0] mod_len;
        logic [7:0] poff;
        logic [7:0] plen;
        logic       pseen;
    } t_rec;

endpackage

// File: hdl/iclp_front.sv
// ----------------------------------------------------------------------------
// iclp_front
// header and tlv walker: labels each byte and tracks the command summary
// ----------------------------------------------------------------------------
module iclp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_byte,
    input  logic          i_last,
    input  logic          i_full,
    output logic          o_push,
    output iclp_pkg::t_rec o_rec
);
    import iclp_pkg::*;

    logic [8:0] r_pos,   n_pos;
    logic [7:0] r_decl,  n_decl;
    logic [7:0] r_mode,  n_mode;
    t_phase     r_phase, n_phase;
    logic [7:0] r_tag,   n_tag;
    logic [7:0] r_vrem,  n_vrem;
    logic [7:0] r_vpos,  n_vpos;
    logic [4:0] r_app,   n_app;
    logic [4:0] r_mod,   n_mod;
    logic [7:0] r_poff,  n_poff;
    logic [7:0] r_plen,  n_plen;
    logic       r_pseen, n_pseen;
    logic [3:0] r_err,   n_err;

    logic [8:0] off9;
    logic [7:0] remv;
    logic [7:0] vrem_dec;
    logic       is_id;
    logic       accept;
    logic [2:0] role;
    logic [7:0] vidx;
    logic [3:0] final_err;
    logic [9:0] end_pos;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept;

    assign off9     = r_pos - 9'(HEADER_BYTES);
    assign remv     = r_decl - off9[7:0];
    assign is_id    = (r_tag == TAG_APP_ID) || (r_tag == TAG_MODULE_ID);
    assign vrem_dec = (r_vrem == 8'd0) ? 8'd0 : r_vrem - 8'd1;

    always_comb begin
        n_pos   = (r_pos != POS_MAX) ? r_pos + 9'd1 : r_pos;
        n_decl  = r_decl;
        n_mode  = r_mode;
        n_phase = r_phase;
        n_tag   = r_tag;
        n_vrem  = r_vrem;
        n_vpos  = r_vpos;
        n_app   = r_app;
        n_mod   = r_mod;
        n_poff  = r_poff;
        n_plen  = r_plen;
        n_pseen = r_pseen;
        n_err   = r_err;
        role    = ROLE_IGNORE;
        vidx    = 8'd0;

        if (r_pos < 9'(HEADER_BYTES)) begin
            role = ROLE_HEADER;
            if (r_pos == POS_P1) begin
                n_mode = i_byte;
                if (i_byte != MODE_SELECTABLE && i_byte != MODE_INSTALL &&
                    r_err == ERR_NONE) begin
                    n_err = ERR_MODE;
                end
            end else if (r_pos == POS_LC) begin
                n_decl = i_byte;
                if (i_byte == 8'd0 && r_err == ERR_NONE) begin
                    n_err = ERR_NO_DATA;
                end
            end
        end else if (off9 < {1'b0, r_decl} && r_err == ERR_NONE) begin
            case (r_phase)
                PH_TAG: begin
                    role  = ROLE_TAG;
                    n_tag = i_byte;
                    if (remv < 8'd2) begin
                        n_err = ERR_TRUNC;
                    end else begin
                        n_phase = PH_LENGTH;
                    end
                end
                PH_LENGTH: begin
                    role = ROLE_LENGTH;
                    if (i_byte > remv - 8'd1) begin
                        n_err = ERR_OVERRUN;
                    end else if (is_id && (i_byte < 8'(MIN_ID_LENGTH) ||
                                           i_byte > 8'(MAX_ID_LENGTH))) begin
                        n_err = ERR_ID_LENGTH;
                    end else begin
                        if (r_tag == TAG_APP_ID) begin
                            n_app = i_byte[4:0];
                        end else if (r_tag == TAG_MODULE_ID) begin
                            n_mod = i_byte[4:0];
                        end else if (r_tag == TAG_PARAMS) begin
                            n_poff  = off9[7:0] + 8'd1;
                            n_plen  = i_byte;
                            n_pseen = 1'b1;
                        end
                        if (i_byte == 8'd0) begin
                            n_phase = PH_TAG;
                        end else begin
                            n_phase = PH_VALUE;
                            n_vrem  = i_byte;
                            n_vpos  = 8'd0;
                        end
                    end
                end
                PH_VALUE: begin
                    if (r_tag == TAG_APP_ID) begin
                        role = ROLE_APP;
                    end else if (r_tag == TAG_MODULE_ID) begin
                        role = ROLE_MODULE;
                    end else if (r_tag == TAG_PARAMS) begin
                        role = ROLE_PARAM;
                    end else begin
                        role = ROLE_SKIP;
                    end
                    vidx   = r_vpos;
                    n_vpos = r_vpos + 8'd1;
                    n_vrem = vrem_dec;
                    if (vrem_dec == 8'd0) begin
                        n_phase = PH_TAG;
                    end
                end
                default: begin
                    n_phase = PH_TAG;
                end
            endcase
        end
    end

    // end-of-command checks, in priority order
    assign end_pos = {1'b0, r_pos} + 10'd1;

    always_comb begin
        final_err = n_err;
        if (n_err == ERR_NONE) begin
            if (r_pos <= POS_P1) begin
                final_err = ERR_TRUNC;
            end else if (r_pos == POS_P2) begin
                final_err = ERR_NO_DATA;
            end else if (end_pos < 10'(HEADER_BYTES) + {2'b00, n_decl}) begin
                final_err = ERR_SHORT;
            end else if (n_app == 5'd0) begin
                final_err = ERR_NO_APP;
            end else if (n_mod == 5'd0) begin
                final_err = ERR_NO_MODULE;
            end
        end
    end

    always_comb begin
        o_rec.role    = role;
        o_rec.value   = i_byte;
        o_rec.vidx    = vidx;
        o_rec.done    = i_last;
        o_rec.cause   = final_err;
        o_rec.install = (n_mode == MODE_INSTALL);
        o_rec.app_len = n_app;
        o_rec.mod_len = n_mod;
        o_rec.poff    = n_poff;
        o_rec.plen    = n_plen;
        o_rec.pseen   = n_pseen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_last)) begin
            r_pos   <= 9'd0;
            r_decl  <= 8'd0;
            r_mode  <= 8'd0;
            r_phase <= PH_TAG;
            r_tag   <= 8'd0;
            r_vrem  <= 8'd0;
            r_vpos  <= 8'd0;
            r_app   <= 5'd0;
            r_mod   <= 5'd0;
            r_poff  <= 8'd0;
            r_plen  <= 8'd0;
            r_pseen <= 1'b0;
            r_err   <= ERR_NONE;
        end else if (accept) begin
            r_pos   <= n_pos;
            r_decl  <= n_decl;
            r_mode  <= n_mode;
            r_phase <= n_phase;
            r_tag   <= n_tag;
            r_vrem  <= n_vrem;
            r_vpos  <= n_vpos;
            r_app   <= n_app;
            r_mod   <= n_mod;
            r_poff  <= n_poff;
            r_plen  <= n_plen;
            r_pseen <= n_pseen;
            r_err   <= n_err;
        end
    end

endmodule

// File: hdl/iclp_queue.sv
// ----------------------------------------------------------------------------
// iclp_queue
// short fifo of classified bytes between front and back
// ----------------------------------------------------------------------------
module iclp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  iclp_pkg::t_rec i_rec,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output iclp_pkg::t_rec o_rec
);
    import iclp_pkg::*;

    t_rec                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr, r_rd;
    logic [QUEUE_AW:0]   r_cnt;
    logic                do_pop;

    assign o_full  = (r_cnt == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_rec   = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: hdl/iclp_back.sv
// ----------------------------------------------------------------------------
// iclp_back
// result stage: maps the cause to a status word and drives the output stream
// ----------------------------------------------------------------------------
module iclp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_pop,
    input  iclp_pkg::t_rec i_rec,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [2:0]     o_role,
    output logic [55:0]    o_data,
    output logic           o_done
);
    import iclp_pkg::*;

    logic        r_valid;
    logic [2:0]  r_role;
    logic [7:0]  r_value, r_vidx;
    logic        r_done;
    logic [1:0]  r_status;
    logic [3:0]  r_cause;
    logic        r_install;
    logic [4:0]  r_app, r_mod;
    logic [7:0]  r_poff, r_plen;
    logic        r_pseen;

    logic        load;
    logic [1:0]  status;

    assign load  = i_valid && (!r_valid || i_ready);
    assign o_pop = load;

    always_comb begin
        case (i_rec.cause)
            ERR_NONE: status = ST_OK;
            ERR_MODE: status = ST_BAD_P1P2;
            default:  status = ST_WRONG_DATA;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // summary fields read as zero except on the closing transfer
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_role    <= i_rec.role;
            r_value   <= i_rec.value;
            r_vidx    <= i_rec.vidx;
            r_done    <= i_rec.done;
            r_status  <= i_rec.done ? status        : ST_OK;
            r_cause   <= i_rec.done ? i_rec.cause   : ERR_NONE;
            r_install <= i_rec.done & i_rec.install;
            r_app     <= i_rec.done ? i_rec.app_len : 5'd0;
            r_mod     <= i_rec.done ? i_rec.mod_len : 5'd0;
            r_poff    <= i_rec.done ? i_rec.poff    : 8'd0;
            r_plen    <= i_rec.done ? i_rec.plen    : 8'd0;
            r_pseen   <= i_rec.done & i_rec.pseen;
        end
    end

    assign o_valid = r_valid;
    assign o_role  = r_role;
    assign o_done  = r_done;
    assign o_data  = {6'd0, r_pseen, r_plen, r_poff, r_mod, r_app, r_install,
                      r_cause, r_status, r_vidx, r_value};

endmodule

// File: hdl/install_command_tlv_parser.sv
// ----------------------------------------------------------------------------
// install_command_tlv_parser
// labels each byte of an install command and reports its parse status
// ----------------------------------------------------------------------------
//  channel   dir  tdata                               tuser      tlast
//  s_axis    in   apdu_byte[7:0]                      -          last_byte
//  m_axis    out  byte_value..params_present (56 b)   byte_role  done_res
//
//  one byte per cycle sustained while the queue has room; a result is written into
//  the queue when its input transfers and is then loaded into the result register.
//  the four-entry queue lets the input keep flowing while the output stalls;
//  the input stalls only once the queue is full.
//  synchronous active-low reset clears the walker, queue and output valid.
//  the walker returns to its reset state after every last byte.
// ----------------------------------------------------------------------------
module install_command_tlv_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] apdu_byte
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] byte_value, [15:8] value_index, [17:16] status, [21:18] error_cause,
    // [22] install_mode, [27:23] app_id_length, [32:28] module_id_length,
    // [40:33] params_offset, [48:41] params_length, [49] params_present
    output logic [55:0] o_m_axis_tdata,
    output logic [2:0]  o_m_axis_tuser,   // [2:0] byte_role
    output logic        o_m_axis_tlast
);
    import iclp_pkg::*;

    t_rec front_rec;
    t_rec queue_rec;
    logic push, full, pop, q_valid;

    iclp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_byte  (i_s_axis_tdata),
        .i_last  (i_s_axis_tlast),
        .i_full  (full),
        .o_push  (push),
        .o_rec   (front_rec)
    );

    iclp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (front_rec),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_rec   (queue_rec)
    );

    iclp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_pop   (pop),
        .i_rec   (queue_rec),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_role  (o_m_axis_tuser),
        .o_data  (o_m_axis_tdata),
        .o_done  (o_m_axis_tlast)
    );

endmodule

// File: tb/sv/install_command_tlv_parser_tb.sv
// ----------------------------------------------------------------------------
// install_command_tlv_parser_tb
// self-checking bench for the install command tlv parser: a short table of
// commands with hand-written roles and causes, then random commands (mostly
// well-formed tlv data, plus broken and noise commands), every output transfer
// compared field by field against a byte-level model of the walker
// ----------------------------------------------------------------------------
module install_command_tlv_parser_tb;

    import iclp_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 1400;
    localparam int TAIL_CYCLES  = 20;
    localparam int LONG_TRAIL   = 520;

    // tlv item kinds
    localparam int IT_APP    = 0;
    localparam int IT_MODULE = 1;
    localparam int IT_PARAMS = 2;
    localparam int IT_OTHER  = 3;
    localparam int IT_EMPTY  = 4;

    // command flaws
    localparam int FL_NONE     = 0;
    localparam int FL_MODE     = 1;
    localparam int FL_NO_DATA  = 2;
    localparam int FL_CUT      = 3;
    localparam int FL_LONE_TAG = 4;
    localparam int FL_OVERRUN  = 5;
    localparam int FL_ID_LEN   = 6;
    localparam int FL_NOISE    = 7;

    typedef struct packed {
        logic [2:0] role;
        logic [7:0] value;
        logic [7:0] vidx;
        logic       done;
        logic [1:0] status;
        logic [3:0] cause;
        logic       install;
        logic [4:0] app_len;
        logic [4:0] mod_len;
        logic [7:0] poff;
        logic [7:0] plen;
        logic       pseen;
    } t_result;

    typedef struct packed {
        logic [7:0] b;
        logic       is_last;
        logic [2:0] role;
        logic [3:0] cause;
    } t_row;

    localparam t_row DIRECTED [26] = '{
        // cut at cla
        '{8'hFF, 1'b1, ROLE_HEADER, ERR_TRUNC},
        // cut at p2
        '{8'h80, 1'b0, ROLE_HEADER, ERR_NONE},
        '{8'hE6, 1'b0, ROLE_HEADER, ERR_NONE},
        '{8'h02, 1'b0, ROLE_HEADER, ERR_NONE},
        '{8'h00, 1'b1, ROLE_HEADER, ERR_NO_DATA},
        // bad p1, data after the error is ignored
        '{8'hFF, 1'b0, ROLE_HEADER, ERR_NONE},
        '{8'hFF, 1'b0, ROLE_HEADER, ERR_NONE},
        '{8'h01, 1'b0, ROLE_HEADER, ERR_NONE},
        '{8'h00, 1'b0, ROLE_HEADER, ERR_NONE},
        '{8'h02, 1'b0, ROLE_HEADER, ERR_NONE},
        '{8'h4F, 1'b0, ROLE_IGNORE, ERR_NONE},
        '{8'h05, 1'b1, ROLE_IGNORE, ERR_MODE},
        // tag as the last data byte
        '{8'h00, 1'b0, ROLE_HEADER, ERR_NONE},
        '{8'h00, 1'b0, ROLE_HEADER, ERR_NONE},
        '{8'h02, 1'b0, ROLE_HEADER, ERR_NONE},
        '{8'h00, 1'b0, ROLE_HEADER, ERR_NONE},
        '{8'h01, 1'b0, ROLE_HEADER, ERR_NONE},
        '{8'hC4, 1'b1, ROLE_TAG,    ERR_TRUNC},
        // item length past the end of data
        '{8'h00, 1'b0, ROLE_HEADER, ERR_NONE},
        '{8'h00, 1'b0, ROLE_HEADER, ERR_NONE},
        '{8'h00, 1'b0, ROLE_HEADER, ERR_NONE},
        '{8'h00, 1'b0, ROLE_HEADER, ERR_NONE},
        '{8'h03, 1'b0, ROLE_HEADER, ERR_NONE},
        '{8'h4F, 1'b0, ROLE_TAG,    ERR_NONE},
        '{8'hFF, 1'b0, ROLE_LENGTH, ERR_NONE},
        '{8'h00, 1'b1, ROLE_IGNORE, ERR_OVERRUN}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    // walker model state
    logic [8:0] pos_cnt;
    logic [7:0] lc_len;
    logic [7:0] p1_byte;
    t_phase     walk;
    logic [7:0] tag_reg;
    logic [7:0] val_left;
    logic [7:0] val_pos;
    logic [4:0] app_len;
    logic [4:0] mod_len;
    logic [7:0] poff;
    logic [7:0] plen;
    logic       pseen;
    logic [3:0] err;

    t_result    pending_q[$];
    logic [7:0] body_q[$];
    logic [7:0] cmd_q[$];
    int         errors = 0;
    int         cycles = 0;
    int         random_sent = 0;
    int         ready_left = 0;
    logic       calm = 1'b0;

    install_command_tlv_parser DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void clear_walker();
        pos_cnt  = '0;
        lc_len   = '0;
        p1_byte  = '0;
        walk     = PH_TAG;
        tag_reg  = '0;
        val_left = '0;
        val_pos  = '0;
        app_len  = '0;
        mod_len  = '0;
        poff     = '0;
        plen     = '0;
        pseen    = 1'b0;
        err      = ERR_NONE;
    endfunction

    function automatic void note_error(input logic [3:0] c);
        if (err == ERR_NONE) begin
            err = c;
        end
    endfunction

    function automatic logic [1:0] status_for(input logic [3:0] c);
        if (c == ERR_NONE) begin
            return ST_OK;
        end
        if (c == ERR_MODE) begin
            return ST_BAD_P1P2;
        end
        return ST_WRONG_DATA;
    endfunction

    // advances the walker model by one command byte
    function automatic t_result predict_byte(input logic [7:0] b, input logic is_last);
        t_result    r;
        logic [8:0] at;
        logic [8:0] off;
        logic [8:0] rem;
        logic       is_id;
        at = pos_cnt;
        r = '0;
        r.role = ROLE_IGNORE;
        r.value = b;
        if (at < HEADER_BYTES) begin
            r.role = ROLE_HEADER;
            if (at == POS_P1) begin
                p1_byte = b;
                if (b != MODE_SELECTABLE && b != MODE_INSTALL) begin
                    note_error(ERR_MODE);
                end
            end else if (at == POS_LC) begin
                lc_len = b;
                if (b == 8'd0) begin
                    note_error(ERR_NO_DATA);
                end
            end
        end else if (at - HEADER_BYTES < lc_len && err == ERR_NONE) begin
            off = at - 9'(HEADER_BYTES);
            // data bytes left, this one included
            rem = {1'b0, lc_len} - off;
            case (walk)
                PH_TAG: begin
                    r.role = ROLE_TAG;
                    tag_reg = b;
                    if (rem < 9'd2) begin
                        note_error(ERR_TRUNC);
                    end else begin
                        walk = PH_LENGTH;
                    end
                end
                PH_LENGTH: begin
                    is_id = (tag_reg == TAG_APP_ID) || (tag_reg == TAG_MODULE_ID);
                    r.role = ROLE_LENGTH;
                    if ({1'b0, b} > rem - 9'd1) begin
                        note_error(ERR_OVERRUN);
                    end else if (is_id && (b < MIN_ID_LENGTH || b > MAX_ID_LENGTH)) begin
                        note_error(ERR_ID_LENGTH);
                    end else begin
                        if (tag_reg == TAG_APP_ID) begin
                            app_len = b[4:0];
                        end else if (tag_reg == TAG_MODULE_ID) begin
                            mod_len = b[4:0];
                        end else if (tag_reg == TAG_PARAMS) begin
                            poff = off[7:0] + 8'd1;
                            plen = b;
                            pseen = 1'b1;
                        end
                        if (b == 8'd0) begin
                            walk = PH_TAG;
                        end else begin
                            walk = PH_VALUE;
                            val_left = b;
                            val_pos = 8'd0;
                        end
                    end
                end
                default: begin
                    if (tag_reg == TAG_APP_ID) begin
                        r.role = ROLE_APP;
                    end else if (tag_reg == TAG_MODULE_ID) begin
                        r.role = ROLE_MODULE;
                    end else if (tag_reg == TAG_PARAMS) begin
                        r.role = ROLE_PARAM;
                    end else begin
                        r.role = ROLE_SKIP;
                    end
                    r.vidx = val_pos;
                    val_pos = val_pos + 8'd1;
                    if (val_left > 8'd0) begin
                        val_left = val_left - 8'd1;
                    end
                    if (val_left == 8'd0) begin
                        walk = PH_TAG;
                    end
                end
            endcase
        end
        if (pos_cnt < POS_MAX) begin
            pos_cnt = pos_cnt + 9'd1;
        end
        if (is_last) begin
            if (err == ERR_NONE) begin
                if (at <= POS_P1) begin
                    note_error(ERR_TRUNC);
                end else if (at == POS_P2) begin
                    note_error(ERR_NO_DATA);
                end else if (at + 1 < HEADER_BYTES + lc_len) begin
                    note_error(ERR_SHORT);
                end else if (app_len == 5'd0) begin
                    note_error(ERR_NO_APP);
                end else if (mod_len == 5'd0) begin
                    note_error(ERR_NO_MODULE);
                end
            end
            r.done    = 1'b1;
            r.cause   = err;
            r.status  = status_for(err);
            r.install = (p1_byte == MODE_INSTALL);
            r.app_len = app_len;
            r.mod_len = mod_len;
            r.poff    = poff;
            r.plen    = plen;
            r.pseen   = pseen;
            clear_walker();
        end
        return r;
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50) begin
            return 0;
        end
        if (r < 85) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic is_last, input logic typed,
                             input logic [2:0] role, input logic [3:0] cause);
        int      gap;
        t_result want;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= is_last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        want = predict_byte(b, is_last);
        if (typed) begin
            want.role = role;
            if (is_last) begin
                want.cause  = cause;
                want.status = status_for(cause);
            end
        end
        pending_q.push_back(want);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_q.size() != 0);
    endtask

    task automatic push_item(input logic [7:0] tag, input int len);
        body_q.push_back(tag);
        body_q.push_back(len[7:0]);
        repeat (len) body_q.push_back(8'($urandom));
    endtask

    task automatic run_command(input int flaw, input int trail);
        int         kinds[$];
        int         n;
        int         len;
        int         keep;
        logic [7:0] tag;
        logic [7:0] p1;
        body_q.delete();
        cmd_q.delete();
        if ($urandom_range(0, 9) != 0) kinds.push_back(IT_APP);
        if ($urandom_range(0, 9) != 0) kinds.push_back(IT_MODULE);
        n = $urandom_range(0, 4);
        repeat (n) kinds.insert($urandom_range(0, kinds.size()), $urandom_range(IT_APP, IT_EMPTY));
        foreach (kinds[i]) begin
            tag = 8'($urandom);
            len = 0;
            case (kinds[i])
                IT_APP: begin
                    tag = TAG_APP_ID;
                    len = $urandom_range(MIN_ID_LENGTH, MAX_ID_LENGTH);
                end
                IT_MODULE: begin
                    tag = TAG_MODULE_ID;
                    len = $urandom_range(MIN_ID_LENGTH, MAX_ID_LENGTH);
                end
                IT_PARAMS: begin
                    tag = TAG_PARAMS;
                    len = $urandom_range(0, 24);
                end
                IT_OTHER: len = $urandom_range(0, 12);
                default: len = 0;
            endcase
            push_item(tag, len);
        end
        // now and then fill the data to the largest length
        if (flaw == FL_NONE && $urandom_range(0, 15) == 0) begin
            push_item(8'hFF, 253 - body_q.size());
        end
        case (flaw)
            FL_LONE_TAG: body_q.push_back(8'($urandom));
            FL_OVERRUN: begin
                n = $urandom_range(0, 3);
                body_q.push_back(8'($urandom));
                body_q.push_back(8'(n + $urandom_range(1, 40)));
                repeat (n) body_q.push_back(8'($urandom));
            end
            FL_ID_LEN: begin
                tag = $urandom_range(0, 1) ? TAG_APP_ID : TAG_MODULE_ID;
                len = $urandom_range(0, 1) ? $urandom_range(0, MIN_ID_LENGTH - 1)
                                           : $urandom_range(MAX_ID_LENGTH + 1, 24);
                body_q.push_back(tag);
                body_q.push_back(len[7:0]);
                repeat (24) body_q.push_back(8'($urandom));
            end
            default: ;
        endcase
        if (flaw == FL_MODE) begin
            do p1 = 8'($urandom); while (p1 == MODE_SELECTABLE || p1 == MODE_INSTALL);
        end else begin
            p1 = $urandom_range(0, 1) ? MODE_INSTALL : MODE_SELECTABLE;
        end
        cmd_q.push_back(8'($urandom));
        cmd_q.push_back(8'($urandom));
        cmd_q.push_back(p1);
        cmd_q.push_back(8'($urandom));
        cmd_q.push_back((flaw == FL_NO_DATA) ? 8'd0 : 8'(body_q.size()));
        foreach (body_q[i]) cmd_q.push_back(body_q[i]);
        repeat (trail) cmd_q.push_back(8'($urandom));
        if (flaw == FL_CUT) begin
            keep = $urandom_range(0, 1) ? $urandom_range(1, HEADER_BYTES)
                                        : $urandom_range(1, cmd_q.size() - 1);
            while (cmd_q.size() > keep) void'(cmd_q.pop_back());
        end else if (flaw == FL_NOISE) begin
            cmd_q.delete();
            repeat ($urandom_range(1, 30)) cmd_q.push_back(8'($urandom));
        end
        foreach (cmd_q[i]) begin
            send_byte(cmd_q[i], i == cmd_q.size() - 1, 1'b0, ROLE_HEADER, ERR_NONE);
        end
        random_sent += cmd_q.size();
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // output side: compare each transfer, then pick the next ready pattern
    always @(posedge clk) begin
        t_result want;
        t_result got;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("install_command_tlv_parser_tb: FAIL");
            $finish;
        end else begin
            if (cycles % 400 == 0) begin
                calm <= ($urandom_range(0, 3) == 0);
            end
            if (rst_n) begin
                if ($isunknown(m_tvalid)) begin
                    $display("%0t: output valid unknown", $time);
                    errors++;
                end else if (m_tvalid && m_tready) begin
                    got.role    = m_tuser;
                    got.value   = m_tdata[7:0];
                    got.vidx    = m_tdata[15:8];
                    got.done    = m_tlast;
                    got.status  = m_tdata[17:16];
                    got.cause   = m_tdata[21:18];
                    got.install = m_tdata[22];
                    got.app_len = m_tdata[27:23];
                    got.mod_len = m_tdata[32:28];
                    got.poff    = m_tdata[40:33];
                    got.plen    = m_tdata[48:41];
                    got.pseen   = m_tdata[49];
                    if (pending_q.size() == 0) begin
                        $display("%0t: unexpected result, expected none, got %h", $time, got);
                        errors++;
                    end else begin
                        want = pending_q.pop_front();
                        check_field("byte_role", 8'(want.role), 8'(got.role));
                        check_field("byte_value", want.value, got.value);
                        check_field("value_index", want.vidx, got.vidx);
                        check_field("done_res", 8'(want.done), 8'(got.done));
                        check_field("status", 8'(want.status), 8'(got.status));
                        check_field("error_cause", 8'(want.cause), 8'(got.cause));
                        check_field("install_mode", 8'(want.install), 8'(got.install));
                        check_field("app_id_length", 8'(want.app_len), 8'(got.app_len));
                        check_field("module_id_length", 8'(want.mod_len),
                                    8'(got.mod_len));
                        check_field("params_offset", want.poff, got.poff);
                        check_field("params_length", want.plen, got.plen);
                        check_field("params_present", 8'(want.pseen), 8'(got.pseen));
                        check_field("tdata padding", 8'd0, 8'(m_tdata[55:50]));
                    end
                end
            end
            if (ready_left > 0) begin
                ready_left <= ready_left - 1;
            end else if (calm || $urandom_range(0, 99) < 70) begin
                m_tready   <= 1'b1;
                ready_left <= $urandom_range(1, 12);
            end else begin
                m_tready   <= 1'b0;
                ready_left <= pick_gap();
            end
        end
    end

    initial begin : stimulus
        int  r;
        int  flaw;
        logic long_done;
        long_done = 1'b0;
        clear_walker();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < $size(DIRECTED); i++) begin
            send_byte(DIRECTED[i].b, DIRECTED[i].is_last, 1'b1, DIRECTED[i].role,
                      DIRECTED[i].cause);
        end
        // hold the input until the output side has caught up
        drain();

        while (random_sent < RANDOM_ITEMS) begin
            if (!long_done && random_sent > RANDOM_ITEMS / 2) begin
                // long enough to run the position counter into saturation
                run_command(FL_NONE, LONG_TRAIL);
                long_done = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 55)      flaw = FL_NONE;
            else if (r < 60) flaw = FL_MODE;
            else if (r < 64) flaw = FL_NO_DATA;
            else if (r < 74) flaw = FL_CUT;
            else if (r < 79) flaw = FL_LONE_TAG;
            else if (r < 85) flaw = FL_OVERRUN;
            else if (r < 92) flaw = FL_ID_LEN;
            else             flaw = FL_NOISE;
            run_command(flaw, (flaw == FL_NONE && $urandom_range(0, 4) == 0) ?
                              $urandom_range(1, 6) : 0);
            if ($urandom_range(0, 19) == 0) begin
                drain();
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0) begin
            $display("install_command_tlv_parser_tb: PASS");
        end else begin
            $display("install_command_tlv_parser_tb: FAIL");
        end
        $finish;
    end

endmodule
